### hdl/sjvc_pkg.sv
package sjvc_pkg;

  // Register map
  localparam int CFG_N  = 8;
  localparam int CFG_W  = 31;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DERIV_GAIN    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_INTEG_GAIN_DT = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ENGAGE_BAND   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RELEASE_BAND  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INTEG_GATE    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RATE_STEP     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_STEPS_PER_RAD = 3'd7;

  // Stream widths
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 96;
  localparam int PERIOD_W   = 24;

  // Control constants
  localparam int DECAY_SHIFT = 6;
  localparam logic [CFG_W-1:0] FF_INERTIA_SCALE  = 31'd65;
  localparam logic [CFG_W-1:0] FF_CORIOLIS_SCALE = 31'd65;
  localparam logic [CFG_W-1:0] FF_GRAVITY_SCALE  = 31'd65;
  localparam longint MIN_HZ = 1;
  localparam longint MAX_HZ = 20000;
  localparam longint Q_ONE  = 65536;
  localparam logic signed [48:0] INTEG_LIMIT  = 49'sd19661;
  localparam logic signed [50:0] WINDUP_LIMIT = 51'sd655360;

  // Frequency range in Q16.16 Hz
  localparam longint FREQ_MAX = MAX_HZ * Q_ONE;
  localparam longint FREQ_MIN = MIN_HZ * Q_ONE;
  localparam int     FREQ_W   = $clog2(FREQ_MAX + 1);

  // Shift-add multiplier
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = CFG_W;
  localparam int PROD_W    = 64;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Restoring divider for one million microseconds in Q16.16
  localparam int DIV_N     = 36;
  localparam int DIV_CNT_W = $clog2(DIV_N);
  localparam logic [DIV_N-1:0] DIV_DIVIDEND = 36'd65536000000;

  typedef enum logic [3:0] {
    S_IDLE, S_BAND, S_DECAY, S_MUL, S_TAKE, S_INT_ADD, S_INT_WIND,
    S_RAW, S_RATE, S_CHECK, S_DIV, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SEL_P, SEL_D, SEL_G, SEL_FI, SEL_FC, SEL_FG, SEL_V
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_BAND, OP_DECAY, OP_MUL, OP_TAKE, OP_INT_ADD,
    OP_INT_WIND, OP_RAW, OP_RATE, OP_DIV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic engage_next;
    logic gate;
    logic freq_ok;
    logic mul_done;
    logic div_done;
  } sts_t;

  // Saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

### hdl/sjvc_ctrl.sv
module sjvc_ctrl
  import sjvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t   state, state_next;
  mul_sel_t sel, sel_next;
  logic     emit;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sel      <= SEL_P;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);

  // Sequence one tick through the shared units
  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd.sel    = sel;
    cmd.op     = OP_NONE;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_BAND;
        end
      end
      S_BAND: begin
        cmd.op = OP_BAND;
        if (sts.engage_next) begin
          sel_next   = SEL_P;
          state_next = S_MUL;
        end else begin
          state_next = S_DECAY;
        end
      end
      S_DECAY: begin
        cmd.op     = OP_DECAY;
        state_next = S_EMIT;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (sts.mul_done) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op = OP_TAKE;
        unique case (sel)
          SEL_P: begin
            sel_next   = SEL_D;
            state_next = S_MUL;
          end
          SEL_D: begin
            sel_next   = sts.gate ? SEL_G : SEL_FI;
            state_next = S_MUL;
          end
          SEL_G:  state_next = S_INT_ADD;
          SEL_FI: begin
            sel_next   = SEL_FC;
            state_next = S_MUL;
          end
          SEL_FC: begin
            sel_next   = SEL_FG;
            state_next = S_MUL;
          end
          SEL_FG: state_next = S_RAW;
          SEL_V:  state_next = S_CHECK;
          default: state_next = S_IDLE;
        endcase
      end
      S_INT_ADD: begin
        cmd.op     = OP_INT_ADD;
        state_next = S_INT_WIND;
      end
      S_INT_WIND: begin
        cmd.op     = OP_INT_WIND;
        sel_next   = SEL_FI;
        state_next = S_MUL;
      end
      S_RAW: begin
        cmd.op     = OP_RAW;
        state_next = S_RATE;
      end
      S_RATE: begin
        cmd.op     = OP_RATE;
        sel_next   = SEL_V;
        state_next = S_MUL;
      end
      S_CHECK: begin
        state_next = sts.freq_ok ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op     = OP_EMIT;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/sjvc_datapath.sv
module sjvc_datapath
  import sjvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_moving,
  output logic [OUT_DATA_W-1:0] out_data,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [CFG_W-1:0] cfg [CFG_N];

  logic signed [31:0] target, measured, rate, term_i, term_c, term_g;
  logic               moving;

  logic               engaged, direction;
  logic signed [31:0] isum, last_vel, raw;
  logic signed [49:0] pd, ff;
  logic signed [47:0] inc;
  logic [FREQ_W-1:0]  freq;
  logic [PERIOD_W-1:0] period;

  logic signed [PROD_W-1:0] acc, acc_next;
  logic [MUL_CNT_W-1:0]     mcnt;
  logic [FREQ_W-1:0]        rem;
  logic [DIV_N-1:0]         quo, quo_next;
  logic [DIV_CNT_W-1:0]     dcnt;

  logic signed [32:0] err;
  logic [32:0]        abs_err;
  logic signed [32:0] abs_vel;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_bit;
  logic signed [47:0]        prod_sh;

  logic signed [48:0] isum_add, isum_clamp;
  logic signed [50:0] pi_sum, pi_abs;
  logic signed [31:0] ff_sat;
  logic signed [32:0] delta, delta_clamp, step_pos;
  logic signed [31:0] vel;
  logic [FREQ_W:0]    rem_sh;
  logic [FREQ_W-1:0]  rem_next;

  // Angle error and its magnitude
  assign err     = 33'(target) - 33'(measured);
  assign abs_err = err[32] ? 33'(-err) : err;
  assign abs_vel = last_vel[31] ? -33'(last_vel) : 33'(last_vel);

  // Deadband hysteresis and status to the controller
  always_comb begin
    if (moving) begin
      sts.engage_next = 1'b1;
    end else if (!engaged && abs_err > 33'(cfg[REG_ENGAGE_BAND])) begin
      sts.engage_next = 1'b1;
    end else if (engaged && abs_err < 33'(cfg[REG_RELEASE_BAND])) begin
      sts.engage_next = 1'b0;
    end else begin
      sts.engage_next = engaged;
    end
    sts.gate     = !moving && (abs_err < 33'(cfg[REG_INTEG_GATE]));
    sts.freq_ok  = (freq >= FREQ_W'(FREQ_MIN)) && (freq != '0);
    sts.mul_done = (mcnt == MUL_CNT_W'(MUL_B_W - 1));
    sts.div_done = (dcnt == DIV_CNT_W'(DIV_N - 1));
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd.sel)
      SEL_P:   begin mul_a = err;               mul_b = cfg[REG_PROP_GAIN];     end
      SEL_D:   begin mul_a = 33'(rate);         mul_b = cfg[REG_DERIV_GAIN];    end
      SEL_G:   begin mul_a = err;               mul_b = cfg[REG_INTEG_GAIN_DT]; end
      SEL_FI:  begin mul_a = 33'(term_i);       mul_b = FF_INERTIA_SCALE;       end
      SEL_FC:  begin mul_a = 33'(term_c);       mul_b = FF_CORIOLIS_SCALE;      end
      SEL_FG:  begin mul_a = 33'(term_g);       mul_b = FF_GRAVITY_SCALE;       end
      SEL_V:   begin mul_a = abs_vel;           mul_b = cfg[REG_STEPS_PER_RAD]; end
      default: begin mul_a = '0;                mul_b = '0;                     end
    endcase
  end

  // One multiplier bit per cycle, most significant first
  assign mul_bit  = mul_b[MUL_CNT_W'(MUL_B_W - 1) - mcnt];
  assign acc_next = ((mcnt == '0) ? '0 : (acc <<< 1)) +
                    (mul_bit ? PROD_W'(mul_a) : '0);
  assign prod_sh  = acc[PROD_W-1:16];

  // Integral accumulate and clamp
  assign isum_add   = 49'(isum) + 49'(inc);
  assign isum_clamp = (isum_add > INTEG_LIMIT)  ? INTEG_LIMIT :
                      (isum_add < -INTEG_LIMIT) ? -INTEG_LIMIT : isum_add;

  // PI magnitude for anti-windup
  assign pi_sum = 51'(pd) + 51'(isum);
  assign pi_abs = pi_sum[50] ? -pi_sum : pi_sum;

  assign ff_sat = sat32(52'(ff));

  // Rate limit
  assign step_pos    = 33'($signed({2'b00, cfg[REG_RATE_STEP]}));
  assign delta       = 33'(raw) - 33'(last_vel);
  assign delta_clamp = (delta > step_pos)  ? step_pos :
                       (delta < -step_pos) ? -step_pos : delta;
  assign vel         = 32'(33'(last_vel) + delta_clamp);

  // One quotient bit per cycle
  assign rem_sh   = {((dcnt == '0) ? '0 : rem), DIV_DIVIDEND[DIV_CNT_W'(DIV_N - 1) - dcnt]};
  assign rem_next = (rem_sh >= {1'b0, freq}) ? FREQ_W'(rem_sh - {1'b0, freq})
                                              : rem_sh[FREQ_W-1:0];
  assign quo_next = {quo[DIV_N-2:0], (rem_sh >= {1'b0, freq})};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_PROP_GAIN]     <= 31'd65536;
      cfg[REG_DERIV_GAIN]    <= 31'd0;
      cfg[REG_INTEG_GAIN_DT] <= 31'd0;
      cfg[REG_ENGAGE_BAND]   <= 31'd655;
      cfg[REG_RELEASE_BAND]  <= 31'd327;
      cfg[REG_INTEG_GATE]    <= 31'd6554;
      cfg[REG_RATE_STEP]     <= 31'd65536;
      cfg[REG_STEPS_PER_RAD] <= 31'd65536;
    end else if (cfg_we) begin
      cfg[cfg_addr] <= cfg_data;
    end
  end

  // Controller state kept across ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      engaged   <= 1'b0;
      isum      <= '0;
      last_vel  <= '0;
      direction <= 1'b0;
      mcnt      <= '0;
      dcnt      <= '0;
    end else begin
      unique case (cmd.op)
        OP_BAND:  engaged <= sts.engage_next;
        OP_DECAY: begin
          isum     <= isum - (isum >>> DECAY_SHIFT);
          last_vel <= '0;
        end
        OP_MUL:   mcnt <= sts.mul_done ? '0 : mcnt + 1'b1;
        OP_INT_ADD: isum <= 32'(isum_clamp);
        OP_INT_WIND: begin
          if (pi_abs > WINDUP_LIMIT &&
              ((err > 0 && isum > 0) || (err < 0 && isum < 0))) begin
            isum <= sat32(52'(isum) - 52'(inc));
          end
        end
        OP_RATE:  last_vel <= vel;
        OP_DIV: begin
          dcnt <= sts.div_done ? '0 : dcnt + 1'b1;
          if (sts.div_done) begin
            direction <= !last_vel[31] && (last_vel != '0);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        target   <= in_data[31:0];
        measured <= in_data[63:32];
        rate     <= in_data[95:64];
        term_i   <= in_data[127:96];
        term_c   <= in_data[159:128];
        term_g   <= in_data[191:160];
        moving   <= in_moving;
        period   <= '0;
      end
      OP_DECAY: begin
        ff  <= '0;
        raw <= '0;
      end
      OP_MUL: acc <= acc_next;
      OP_TAKE: begin
        unique case (cmd.sel)
          SEL_P:  pd  <= 50'(prod_sh);
          SEL_D:  pd  <= pd - 50'(prod_sh);
          SEL_G:  inc <= prod_sh;
          SEL_FI: ff  <= 50'(prod_sh);
          SEL_FC: ff  <= ff + 50'(prod_sh);
          SEL_FG: ff  <= ff + 50'(prod_sh);
          SEL_V: begin
            freq <= (prod_sh > 48'(FREQ_MAX)) ? FREQ_W'(FREQ_MAX)
                                              : prod_sh[FREQ_W-1:0];
          end
          default: ;
        endcase
      end
      OP_RAW: begin
        ff  <= 50'(ff_sat);
        raw <= sat32(52'(pd) + 52'(isum) + 52'(ff_sat));
      end
      OP_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        if (sts.div_done) begin
          period <= quo_next[PERIOD_W-1:0];
        end
      end
      OP_EMIT: begin
        out_data <= {6'd0, raw, ff[31:0], engaged, direction, period};
      end
      default: ;
    endcase
  end

endmodule

### hdl/stepper_joint_velocity_controller_top.sv
// Joint velocity controller for a stepper-driven joint, one result per control
// tick. An engaged tick runs up to seven products through one shift-add
// multiplier (31 bit steps plus a step to take the product), a restoring
// divider with a 36-bit quotient for the step period, and eight single steps.
// Without the integral the tick drops two steps and one product, and a tick
// with no stepping skips the divider. A released tick only loads, checks the
// band, decays and emits. A new tick is accepted once the previous one has
// been placed in the output register, which may still wait for its transfer.
// Configuration is written through cfg_we/cfg_addr/cfg_data; the user must
// write it only while no tick is in flight, as the block does not enforce it.
module stepper_joint_velocity_controller_top
  import sjvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // target_angle, measured_angle, measured_rate, inertia_term,
  // coriolis_term, gravity_term (32 bits each)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // moving
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // step_period (24), step_direction, drive_active, ff_increment (32),
  // raw_velocity (32), zero fill (6)
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  sjvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sjvc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_moving (s_tuser),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### sim/tb_stepper_joint_velocity_controller_top.sv
module tb_stepper_joint_velocity_controller_top;
  import sjvc_pkg::*;

  typedef struct {
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic signed [31:0] rate;
    logic               moving;
    logic signed [31:0] inertia;
    logic signed [31:0] coriolis;
    logic signed [31:0] gravity;
  } tick_t;

  typedef struct {
    logic [PERIOD_W-1:0] period;
    logic                direction;
    logic                active;
    logic signed [31:0]  ff;
    logic signed [31:0]  raw;
  } cmd_out_t;

  typedef struct {
    tick_t    t;
    bit       has_exp;
    cmd_out_t exp;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  // target_angle, measured_angle, measured_rate, inertia_term,
  // coriolis_term, gravity_term (32 bits each)
  logic [IN_DATA_W-1:0]  s_tdata;
  // moving
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // step_period (24), step_direction, drive_active, ff_increment (32),
  // raw_velocity (32), zero fill (6)
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predictor state and register copy
  logic [CFG_W-1:0] gains [CFG_N];
  bit               engaged_q;
  longint           integ_q;
  longint           vel_q;
  bit               dir_q;

  cmd_out_t expected_cmds [$];
  int       mismatches;
  int       checked;
  int       stepping_seen;
  bit       rx_free_run;
  bit       tx_free_run;
  int       rx_stall;

  stepper_joint_velocity_controller_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb_stepper_joint_velocity_controller_top: done, errors");
    $finish;
  end

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mag(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Advance the controller by one tick and return its command
  function automatic cmd_out_t control_tick(input tick_t t);
    cmd_out_t r;
    longint err, aerr, pd, inc, ff, raw, delta, lim, vel, freq, sum;
    err  = longint'(t.target) - longint'(t.measured);
    aerr = mag(err);
    r = '{default: '0};
    if (t.moving) engaged_q = 1'b1;
    else if (!engaged_q && aerr > longint'(gains[REG_ENGAGE_BAND])) engaged_q = 1'b1;
    else if (engaged_q && aerr < longint'(gains[REG_RELEASE_BAND])) engaged_q = 1'b0;

    // Released: decay the integral, drop velocity memory, hold direction
    if (!engaged_q) begin
      integ_q = integ_q - (integ_q >>> DECAY_SHIFT);
      vel_q = 0;
      r.direction = dir_q;
      return r;
    end

    pd = ((longint'(gains[REG_PROP_GAIN]) * err) >>> 16)
       - ((longint'(gains[REG_DERIV_GAIN]) * longint'(t.rate)) >>> 16);

    // Gated integral with clamp and anti-windup
    if (!t.moving && aerr < longint'(gains[REG_INTEG_GATE])) begin
      inc = (longint'(gains[REG_INTEG_GAIN_DT]) * err) >>> 16;
      integ_q += inc;
      if (integ_q > 19661) integ_q = 19661;
      if (integ_q < -19661) integ_q = -19661;
      sum = pd + integ_q;
      if (mag(sum) > 655360 &&
          ((err > 0 && integ_q > 0) || (err < 0 && integ_q < 0)))
        integ_q = clip32(integ_q - inc);
    end

    ff = ((65 * longint'(t.inertia)) >>> 16) + ((65 * longint'(t.coriolis)) >>> 16)
       + ((65 * longint'(t.gravity)) >>> 16);
    ff = clip32(ff);
    raw = clip32(pd + integ_q + ff);

    // Rate limit, then frequency and period
    lim = longint'(gains[REG_RATE_STEP]);
    delta = raw - vel_q;
    if (delta > lim) delta = lim;
    if (delta < -lim) delta = -lim;
    vel = vel_q + delta;
    vel_q = vel;
    freq = (mag(vel) * longint'(gains[REG_STEPS_PER_RAD])) >>> 16;
    if (freq > FREQ_MAX) freq = FREQ_MAX;
    if (freq >= FREQ_MIN && freq > 0) begin
      r.period = PERIOD_W'(64'd65536000000 / freq);
      dir_q = vel > 0;
    end
    r.direction = dir_q;
    r.active = 1'b1;
    r.ff = ff[31:0];
    r.raw = raw[31:0];
    return r;
  endfunction

  function automatic tick_t mk_tick(input logic signed [31:0] tg, ms, rt, input logic mv,
                                    input logic signed [31:0] fi, fc, fg);
    tick_t t;
    t = '{tg, ms, rt, mv, fi, fc, fg};
    return t;
  endfunction

  function automatic logic signed [31:0] rnd_signed();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  // Mostly small errors so the deadband and integral paths get exercised
  function automatic tick_t rnd_tick();
    tick_t t;
    int sel;
    sel = $urandom_range(0, 9);
    t.measured = $urandom;
    if (sel < 5) t.target = t.measured + $signed($urandom_range(0, 20000)) - 10000;
    else if (sel < 7) t.target = t.measured + ($signed($urandom) >>> 11);
    else if (sel < 9) t.target = $urandom;
    else begin
      t.target = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      t.measured = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    end
    t.rate = rnd_signed();
    t.moving = ($urandom_range(0, 3) == 0);
    t.inertia = ($urandom_range(0, 2) == 0) ? rnd_signed() : 32'sd0;
    t.coriolis = ($urandom_range(0, 2) == 0) ? rnd_signed() : 32'sd0;
    t.gravity = ($urandom_range(0, 2) == 0) ? rnd_signed() : 32'sd0;
    return t;
  endfunction

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    gains[idx] = val;
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one tick and hold until the transfer
  task automatic send_tick(input tick_t t, input bit has_exp, input cmd_out_t exp);
    int gap;
    cmd_out_t p;
    gap = 0;
    if (!tx_free_run) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8:          gap = $urandom_range(1, 3);
        default:          gap = $urandom_range(10, 80);
      endcase
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {t.gravity, t.coriolis, t.inertia, t.rate, t.measured, t.target};
    s_tuser <= t.moving;
    do @(posedge clk); while (!s_tready);
    p = control_tick(t);
    expected_cmds.push_back(has_exp ? exp : p);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_free_run) begin
      m_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          rx_stall <= $urandom_range(0, 3);
          m_tready <= 1'b0;
        end
        3: begin
          rx_stall <= $urandom_range(20, 120);
          m_tready <= 1'b0;
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    cmd_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command %h", m_tdata);
      end else begin
        e = expected_cmds.pop_front();
        checked++;
        if (m_tdata[24] != 1'b0 || m_tdata[23:0] != 0) stepping_seen++;
        if (m_tdata[23:0] !== e.period || m_tdata[24] !== e.direction ||
            m_tdata[25] !== e.active || m_tdata[57:26] !== e.ff ||
            m_tdata[89:58] !== e.raw || m_tdata[95:90] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: exp per=%0d dir=%b act=%b ff=%0d raw=%0d, ",
                      "got per=%0d dir=%b act=%b ff=%0d raw=%0d fill=%b"},
                     checked, e.period, e.direction, e.active, e.ff, e.raw,
                     m_tdata[23:0], m_tdata[24], m_tdata[25], $signed(m_tdata[57:26]),
                     $signed(m_tdata[89:58]), m_tdata[95:90]);
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    cmd_out_t z;
    cmd_out_t noexp;
    int phase;
    int i;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    rx_stall = 0;
    rx_free_run = 1'b0;
    tx_free_run = 1'b0;
    mismatches = 0;
    checked = 0;
    stepping_seen = 0;
    gains = '{31'd65536, 31'd0, 31'd0, 31'd655, 31'd327, 31'd6554, 31'd65536, 31'd65536};
    engaged_q = 1'b0;
    integ_q = 0;
    vel_q = 0;
    dir_q = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks at reset settings; typed results where obvious
    z = '{default: '0};
    noexp = z;
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_tick(100, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_tick(1000, 0, 0, 0, 0, 0, 0), 1,
                     '{24'd0, 1'b0, 1'b1, 32'sd0, 32'sd1000}});
    rows.push_back('{mk_tick(200, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_tick(32'sh7FFFFFFF, 32'sh80000000, 0, 1, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(32'sh80000000, 32'sh7FFFFFFF, 0, 1, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(0, 0, 32'sh7FFFFFFF, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF), 0, noexp});
    rows.push_back('{mk_tick(0, 0, 32'sh80000000, 1, 32'sh80000000, 32'sh80000000,
                             32'sh80000000), 0, noexp});
    rows.push_back('{mk_tick(300000, 0, 0, 1, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(300000, 0, 0, 1, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(-300000, 0, 0, 1, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(3000, 0, 0, 0, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(-3000, 0, 0, 0, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(500, 0, 0, 0, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(100, 0, 0, 0, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(50, 0, 0, 0, 0, 0, 0), 0, noexp});
    rows.push_back('{mk_tick(0, 0, -65536, 0, 655360, -655360, 65536), 0, noexp});
    foreach (rows[k]) send_tick(rows[k].t, rows[k].has_exp, rows[k].exp);
    drain();

    // Random ticks over several register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: for (i = 0; i < CFG_N; i++) cfg_write(i[CFG_AW-1:0], 31'h7FFFFFFF);
        1: for (i = 0; i < CFG_N; i++) cfg_write(i[CFG_AW-1:0], 31'd0);
        2: begin
          cfg_write(REG_PROP_GAIN, 31'd65536);
          cfg_write(REG_DERIV_GAIN, 31'd0);
          cfg_write(REG_INTEG_GAIN_DT, 31'd0);
          cfg_write(REG_ENGAGE_BAND, 31'd655);
          cfg_write(REG_RELEASE_BAND, 31'd327);
          cfg_write(REG_INTEG_GATE, 31'd6554);
          cfg_write(REG_RATE_STEP, 31'd65536);
          cfg_write(REG_STEPS_PER_RAD, 31'd65536);
        end
        default: begin
          cfg_write(REG_PROP_GAIN, CFG_W'($urandom_range(0, 1 << 24)));
          cfg_write(REG_DERIV_GAIN, CFG_W'($urandom_range(0, 1 << 18)));
          cfg_write(REG_INTEG_GAIN_DT, CFG_W'($urandom_range(0, 1 << 26)));
          cfg_write(REG_ENGAGE_BAND, CFG_W'($urandom_range(0, 8000)));
          cfg_write(REG_RELEASE_BAND, CFG_W'($urandom_range(0, 4000)));
          cfg_write(REG_INTEG_GATE, CFG_W'($urandom_range(0, 20000)));
          cfg_write(REG_RATE_STEP, CFG_W'($urandom_range(0, 1 << 23)));
          cfg_write(REG_STEPS_PER_RAD, CFG_W'($urandom_range(1, 1 << 28)));
        end
      endcase
      cfg_done();
      for (i = 0; i < 215; i++) begin
        tx_free_run = (i >= 80 && i < 110);
        rx_free_run = (i >= 95 && i < 125);
        send_tick(rnd_tick(), 0, noexp);
        // Hold the sender until everything has come back
        if (i == 150) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          while (expected_cmds.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d commands over 7 register settings, %0d with direction or stepping set",
             checked, stepping_seen);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("tb_stepper_joint_velocity_controller_top: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_stepper_joint_velocity_controller_top: done, errors");
    end
    $finish;
  end

endmodule
